// ===== src/csg_pkg.sv =====
// Shared constants, types and opcodes for the induced subgraph extractor.
`timescale 1ns / 1ps
package csg_pkg;
  localparam int MaxNodesDefault = 1024;
  localparam int MaxEdgesDefault = 8192;
  localparam int OpW = 3;
  localparam int AddrW = 13;
  localparam int ValW = 14;
  localparam int RowW = 10;
  localparam int CfgW = 11;
  localparam int EidxW = 13;

  localparam logic [OpW-1:0] OP_WR_ROW = 3'd0;
  localparam logic [OpW-1:0] OP_WR_COL = 3'd1;
  localparam logic [OpW-1:0] OP_SELECT = 3'd2;
  localparam logic [OpW-1:0] OP_STEP   = 3'd3;
  localparam logic [OpW-1:0] OP_CLEAR  = 3'd4;

  // One input beat.
  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [AddrW-1:0] address;
    logic [ValW-1:0]  value;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic             kept;
    logic [RowW-1:0]  sub_row;
    logic [RowW-1:0]  sub_col;
    logic [EidxW-1:0] edge_index;
    logic             done_res;
    logic             error;
  } out_item_t;
endpackage

// ===== src/csg_if.sv =====
// Valid/ready channel interfaces for input and result beats.
`timescale 1ns / 1ps
interface csg_in_if import csg_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface csg_out_if import csg_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/csg_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module csg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/csg_fifo.sv =====
// Two-entry queue between the front and the back.
`timescale 1ns / 1ps
module csg_fifo import csg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t push_data,
  output logic     full,
  input  logic     pop,
  output in_item_t pop_data,
  output logic     empty
);
  in_item_t slot [2];
  logic     wptr;
  logic     rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_data = slot[rptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_data;
    end
  end
endmodule

// ===== src/csg_back.sv =====
// Back part: executes beats against the graph memories and drives results.
`timescale 1ns / 1ps
module csg_back import csg_pkg::*; #(
  parameter int MaxNodes = MaxNodesDefault,
  parameter int MaxEdges = MaxEdgesDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CfgW-1:0] node_count,
  input  logic            q_empty,
  input  in_item_t        q_data,
  output logic            q_pop,
  csg_out_if.source       res
);
  localparam int NW = $clog2(MaxNodes);
  localparam int EW = $clog2(MaxEdges);
  localparam int PW = $clog2(MaxNodes + 1);
  localparam int RpW = $clog2(MaxEdges + 1);
  localparam int RpD = MaxNodes + 1;
  localparam int RpAW = $clog2(RpD);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EXEC, S_ROWA, S_ROWB, S_ROWC, S_EDGE, S_COL, S_MAP, S_LIST, S_OUT
  } state_t;

  state_t state;
  in_item_t cur;
  logic [PW-1:0] sel_count;
  logic [PW-1:0] cur_node;
  logic [RpW-1:0] cur_edge;
  logic [RpW-1:0] cur_end;
  logic row_active;
  logic [NW-1:0] init_addr;
  logic [NW-1:0] tgt;
  logic [NW-1:0] tgt_pos;
  logic acc_kept;
  logic [RowW-1:0] acc_row;
  logic [RowW-1:0] acc_col;
  logic [EidxW-1:0] acc_eidx;
  logic acc_err;
  out_item_t res_q;
  logic res_valid;

  // Effective node count saturated into 1..MaxNodes.
  logic [PW:0] n_use;
  always_comb begin
    if (node_count == '0) begin
      n_use = (PW + 1)'(1);
    end else if (32'(node_count) > MaxNodes) begin
      n_use = (PW + 1)'(MaxNodes);
    end else begin
      n_use = (PW + 1)'(node_count);
    end
  end

  // Memory ports.
  logic rp_we, ct_we, pm_we, sl_we;
  logic [RpAW-1:0] rp_waddr, rp_raddr;
  logic [RpW-1:0] rp_rdata;
  logic [EW-1:0] ct_waddr, ct_raddr;
  logic [NW-1:0] ct_rdata;
  logic [NW-1:0] pm_waddr, pm_raddr;
  logic [NW-1:0] pm_wdata;
  logic [NW-1:0] pm_rdata;
  logic [NW-1:0] sl_waddr, sl_raddr;
  logic [NW-1:0] sl_rdata;

  csg_ram #(.Width(RpW), .Depth(RpD)) u_rp (
    .clk, .we(rp_we), .waddr(rp_waddr), .wdata(RpW'(cur.value)),
    .raddr(rp_raddr), .rdata(rp_rdata));
  csg_ram #(.Width(NW), .Depth(MaxEdges)) u_ct (
    .clk, .we(ct_we), .waddr(ct_waddr), .wdata(NW'(cur.value)),
    .raddr(ct_raddr), .rdata(ct_rdata));
  csg_ram #(.Width(NW), .Depth(MaxNodes)) u_pm (
    .clk, .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata));
  csg_ram #(.Width(NW), .Depth(MaxNodes)) u_sl (
    .clk, .we(sl_we), .waddr(sl_waddr), .wdata(NW'(cur.value)),
    .raddr(sl_raddr), .rdata(sl_rdata));

  // Decode checks on the current beat.
  logic wr_row_ok, wr_col_ok, sel_ok, walking;
  logic sel_go, exec_err;
  assign wr_row_ok = ({4'd0, cur.address} <= 17'(n_use)) &&
                     (32'(cur.value) <= MaxEdges);
  assign wr_col_ok = (32'(cur.address) < MaxEdges) &&
                     ({3'd0, cur.value} < 17'(n_use));
  assign sel_ok = ({3'd0, cur.value} < 17'(n_use)) && (32'(sel_count) < MaxNodes);
  assign walking = (cur_node < sel_count);
  assign sel_go = (state == S_EXEC) && (cur.opcode == OP_SELECT) && sel_ok;

  always_comb begin
    unique case (cur.opcode) inside
      OP_WR_ROW: exec_err = !wr_row_ok;
      OP_WR_COL: exec_err = !wr_col_ok;
      OP_SELECT: exec_err = !sel_ok;
      OP_STEP, OP_CLEAR: exec_err = 1'b0;
      default: exec_err = 1'b1;
    endcase
  end

  // Walk checks: the edge cursor against the row end, and the selection test of a target.
  // A target is selected when its map entry points into the current list at itself.
  logic edge_over, last_edge, hit;
  assign edge_over = (cur_edge >= cur_end) || (32'(cur_edge) >= MaxEdges);
  assign last_edge = (cur_edge + RpW'(1) >= cur_end);
  assign hit = (PW'(tgt_pos) < sel_count) && (sl_rdata == tgt);

  assign rp_we = (state == S_EXEC) && (cur.opcode == OP_WR_ROW) && wr_row_ok;
  assign rp_waddr = RpAW'(cur.address);
  assign ct_we = (state == S_EXEC) && (cur.opcode == OP_WR_COL) && wr_col_ok;
  assign ct_waddr = EW'(cur.address);
  assign ct_raddr = EW'(cur_edge);
  assign pm_we = (state == S_INIT) || sel_go;
  assign pm_waddr = (state == S_INIT) ? init_addr : NW'(cur.value);
  assign pm_wdata = (state == S_INIT) ? '0 : NW'(sel_count);
  assign pm_raddr = ct_rdata;
  assign sl_we = sel_go;
  assign sl_waddr = NW'(sel_count);
  assign sl_raddr = (state == S_MAP) ? pm_rdata : NW'(cur_node);
  // Row pointer reads: start issued in S_ROWA, end in S_ROWB.
  assign rp_raddr = (state == S_ROWB) ? RpAW'(sl_rdata) + RpAW'(1) : RpAW'(sl_rdata);

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign res.valid = res_valid;
  assign res.payload = res_q;

  // Sequencer; S_INIT clears the position map once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_addr <= '0;
      sel_count <= '0;
      cur_node <= '0;
      cur_edge <= '0;
      cur_end <= '0;
      row_active <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          init_addr <= init_addr + NW'(1);
          if (32'(init_addr) == MaxNodes - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          acc_kept <= 1'b0;
          acc_row <= '0;
          acc_col <= '0;
          acc_eidx <= '0;
          acc_err <= exec_err;
          if (cur.opcode == OP_STEP && walking) begin
            state <= row_active ? S_EDGE : S_ROWA;
          end else begin
            state <= S_OUT;
          end
          if (sel_go) begin
            sel_count <= sel_count + PW'(1);
          end else if (cur.opcode == OP_CLEAR) begin
            sel_count <= '0;
            cur_node <= '0;
            cur_edge <= '0;
            cur_end <= '0;
            row_active <= 1'b0;
          end
        end
        S_ROWA: begin
          state <= S_ROWB;
        end
        S_ROWB: begin
          // Row start has arrived; the end read is issued now.
          cur_edge <= rp_rdata;
          state <= S_ROWC;
        end
        S_ROWC: begin
          cur_end <= rp_rdata;
          row_active <= 1'b1;
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (edge_over) begin
            cur_node <= cur_node + PW'(1);
            row_active <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_COL;
          end
        end
        S_COL: begin
          // Column target is on ct_rdata; its map read is issued.
          tgt <= ct_rdata;
          state <= S_MAP;
        end
        S_MAP: begin
          // Map entry is on pm_rdata; the list read at that position is issued.
          tgt_pos <= pm_rdata;
          state <= S_LIST;
        end
        S_LIST: begin
          acc_kept <= hit;
          if (hit) begin
            acc_row <= RowW'(cur_node);
            acc_col <= RowW'(tgt_pos);
            acc_eidx <= EidxW'(cur_edge);
          end
          cur_edge <= cur_edge + RpW'(1);
          if (last_edge) begin
            cur_node <= cur_node + PW'(1);
            row_active <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || res.ready) begin
            res_q <= {acc_kept, acc_row, acc_col, acc_eidx, !walking, acc_err};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Result register handshake.
      if (state == S_OUT && (!res_valid || res.ready)) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end
endmodule

// ===== src/csg_front.sv =====
// Front part: accepts input beats and queues them for the back.
`timescale 1ns / 1ps
module csg_front import csg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  csg_in_if.sink  req,
  input  logic    pop,
  output in_item_t pop_data,
  output logic    empty
);
  logic full;
  logic push;

  assign req.ready = !full;
  assign push = req.valid && !full;

  csg_fifo u_fifo (
    .clk, .rst, .push, .push_data(req.payload), .full,
    .pop, .pop_data, .empty);
endmodule

// ===== src/csr_induced_subgraph_extract.sv =====
// Top level of the induced subgraph extractor.
//
//  channel  dir  handshake        payload
//  req      in   valid/ready      opcode, address, value
//  res      out  valid/ready      kept, sub_row, sub_col, edge_index, done_res, error
//  cfg      in   cfg_we           cfg_wdata = node_count
//
// Writes, selects, clears and steps past the end go through the pop, execute and result
// states. A step for an edge of an open row also goes through the column target, position
// map and list check reads, which are chained; opening a row adds the list read and the
// start and end row pointer reads. After reset (rst, synchronous) the back clears the
// whole position map before it takes beats. A two-beat queue takes input while the back
// is busy; a result waiting for ready holds the back in its output state.
`timescale 1ns / 1ps
module csr_induced_subgraph_extract import csg_pkg::*; #(
  parameter int MaxNodes = MaxNodesDefault,
  parameter int MaxEdges = MaxEdgesDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [CfgW-1:0] cfg_wdata,
  csg_in_if.sink          req,
  csg_out_if.source       res
);
  logic [CfgW-1:0] node_count;
  logic q_pop, q_empty;
  in_item_t q_data;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CfgW'(1024);
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  csg_front u_front (
    .clk, .rst, .req, .pop(q_pop), .pop_data(q_data), .empty(q_empty));

  csg_back #(.MaxNodes(MaxNodes), .MaxEdges(MaxEdges)) u_back (
    .clk, .rst, .node_count, .q_empty, .q_data, .q_pop, .res);
endmodule

// ===== src/csg_checker.sv =====
// Port-level checker for the extractor, bound to the top level.
`timescale 1ns / 1ps
module csg_checker import csg_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_ready,
  input out_item_t res_payload
);
  // A result that is not kept carries a zero sub_row and edge_index.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_payload.kept |-> res_payload.sub_row == '0 &&
    res_payload.edge_index == '0) else $error("nonzero fields on drop");
  // A kept edge is never an error.
  a_kept: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_payload.kept && res_payload.error))
    else $error("kept with error");
  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_payload))
    else $error("result dropped under stall");
endmodule

bind csr_induced_subgraph_extract csg_checker u_chk (
  .clk, .rst, .res_valid(res.valid), .res_ready(res.ready), .res_payload(res.payload));

// ===== verif/tb_top.sv =====
// Self-checking testbench for the induced subgraph extractor: directed, list-full and random jobs.
`timescale 1ns / 1ps
module tb_top;
  import csg_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgW-1:0] cfg_wdata;

  csg_in_if req();
  csg_out_if res();

  csr_induced_subgraph_extract dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req(req),
    .res(res)
  );

  localparam int NodeLimit = 1024;
  localparam int EdgeLimit = 8192;
  localparam int SettleCycles = 30;

  // Shadow copy of the graph, the selection and the walk.
  logic [ValW-1:0] row_ptr_mem [0:NodeLimit];
  logic [RowW-1:0] col_mem [0:EdgeLimit-1];
  bit in_map [0:NodeLimit-1];
  int unsigned map_pos [0:NodeLimit-1];
  int unsigned sel_list [0:NodeLimit-1];
  int unsigned sel_count;
  int unsigned walk_node;
  int unsigned walk_edge;
  int unsigned walk_end;
  bit walking;
  int unsigned node_cfg;

  out_item_t expected_q[$];
  int fails;
  int sent;
  int gap_pct;
  int stall_pct;

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void reset_job();
    for (int i = 0; i < NodeLimit; i++) begin
      in_map[i] = 1'b0;
      map_pos[i] = 0;
    end
    sel_count = 0;
    walk_node = 0;
    walk_edge = 0;
    walk_end = 0;
    walking = 1'b0;
  endfunction

  // Computes the result beat of one input beat and updates the shadow state.
  function automatic out_item_t extract_result(in_item_t it);
    out_item_t r;
    int unsigned n;
    int unsigned addr;
    int unsigned val;
    int unsigned v;
    int unsigned w;
    r = '0;
    n = node_cfg;
    if (n == 0) n = 1;
    if (n > NodeLimit) n = NodeLimit;
    addr = it.address;
    val = it.value;
    case (it.opcode)
      OP_WR_ROW: begin
        if (addr > n || val > EdgeLimit) r.error = 1'b1;
        else row_ptr_mem[addr] = val[ValW-1:0];
      end
      OP_WR_COL: begin
        if (addr >= EdgeLimit || val >= n) r.error = 1'b1;
        else col_mem[addr] = val[RowW-1:0];
      end
      OP_SELECT: begin
        if (val >= n || sel_count >= NodeLimit) begin
          r.error = 1'b1;
        end else begin
          sel_list[sel_count] = val;
          map_pos[val] = sel_count;
          in_map[val] = 1'b1;
          sel_count++;
        end
      end
      OP_STEP: begin
        if (walk_node < sel_count) begin
          if (!walking) begin
            v = sel_list[walk_node];
            walk_edge = row_ptr_mem[v];
            walk_end = row_ptr_mem[v+1];
            walking = 1'b1;
          end
          if (walk_edge >= walk_end || walk_edge >= EdgeLimit) begin
            walk_node++;
            walking = 1'b0;
          end else begin
            w = col_mem[walk_edge];
            if (in_map[w]) begin
              r.kept = 1'b1;
              r.sub_row = walk_node[RowW-1:0];
              r.sub_col = map_pos[w][RowW-1:0];
              r.edge_index = walk_edge[EidxW-1:0];
            end
            walk_edge++;
            if (walk_edge >= walk_end) begin
              walk_node++;
              walking = 1'b0;
            end
          end
        end
      end
      OP_CLEAR: reset_job();
      default: r.error = 1'b1;
    endcase
    r.done_res = (walk_node >= sel_count);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  // Result checker; also drives receiver stalls.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && res.valid && res.ready) begin
      got = res.payload;
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        fails++;
      end else begin
        want = expected_q.pop_front();
        check_field("kept", want.kept, got.kept);
        check_field("sub_row", want.sub_row, got.sub_row);
        check_field("sub_col", want.sub_col, got.sub_col);
        check_field("edge_index", want.edge_index, got.edge_index);
        check_field("done_res", want.done_res, got.done_res);
        check_field("error", want.error, got.error);
      end
    end
    res.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void set_phase(int p);
    case (p % 4)
      0: begin gap_pct = 0; stall_pct = 0; end
      1: begin gap_pct = 45; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 45; end
      default: begin gap_pct = 36; stall_pct = 36; end
    endcase
  endfunction

  // Sends one beat, with an optional idle gap first, and records its expectation.
  task automatic send_beat(logic [OpW-1:0] op, int unsigned addr, int unsigned val);
    in_item_t it;
    it.opcode = op;
    it.address = addr[AddrW-1:0];
    it.value = val[ValW-1:0];
    if ($urandom_range(99) < gap_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= it;
    do @(posedge clk); while (!req.ready);
    expected_q.insert(expected_q.size(), extract_result(it));
    sent++;
  endtask

  // Holds the sender until every expected result has come back.
  task automatic drain();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_node_count(int unsigned n);
    drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n[CfgW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    node_cfg = n;
  endtask

  // One refused beat of a random kind.
  task automatic send_noise(int unsigned n);
    case ($urandom_range(5))
      0: send_beat(3'($urandom_range(5, 7)), $urandom, $urandom);
      1: send_beat(OP_WR_ROW, $urandom_range(n + 1, 8191), $urandom_range(0, 8192));
      2: send_beat(OP_WR_ROW, $urandom_range(0, n), $urandom_range(8193, 16383));
      3: send_beat(OP_WR_COL, $urandom_range(0, 8191), $urandom_range(n, 16383));
      default: send_beat(OP_SELECT, $urandom, $urandom_range(n, 16383));
    endcase
  endtask

  // Builds a graph window [base, base+m], selects nodes in it and walks it.
  task automatic run_job(int unsigned n, int unsigned base, int unsigned m, int nsel,
                         int extra, bit at_top, int noise_pct);
    int deg[];
    int total;
    int offset;
    int pos;
    int steps;
    int unsigned v;
    deg = new[m];
    total = 0;
    foreach (deg[i]) begin
      deg[i] = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 5);
      total += deg[i];
    end
    offset = at_top ? EdgeLimit - total : $urandom_range(0, EdgeLimit - total);
    send_beat(OP_CLEAR, $urandom, $urandom);
    pos = offset;
    for (int i = 0; i <= m; i++) begin
      send_beat(OP_WR_ROW, base + i, pos);
      if (i < m) pos += deg[i];
    end
    for (int e = offset; e < offset + total; e++) begin
      if ($urandom_range(9) < 7) send_beat(OP_WR_COL, e, base + $urandom_range(m - 1));
      else send_beat(OP_WR_COL, e, $urandom_range(n - 1));
    end
    steps = extra;
    for (int s = 0; s < nsel; s++) begin
      v = base + $urandom_range(m - 1);
      send_beat(OP_SELECT, $urandom, v);
      steps += (deg[v - base] > 0) ? deg[v - base] : 1;
      if ($urandom_range(99) < noise_pct) send_noise(n);
    end
    for (int s = 0; s < steps; s++) begin
      send_beat(OP_STEP, $urandom, $urandom);
      if ($urandom_range(99) < noise_pct) send_noise(n);
    end
  endtask

  // Extremes of the fields, refused opcodes and out-of-range fields, stepping past the end.
  task automatic test_directed();
    set_phase(0);
    send_beat(3'd5, 0, 0);
    send_beat(3'd6, 8191, 16383);
    send_beat(3'd7, 4096, 8192);
    send_beat(OP_STEP, 0, 0);
    send_beat(OP_WR_ROW, 1025, 0);
    send_beat(OP_WR_ROW, 0, 8193);
    send_beat(OP_WR_COL, 8191, 1024);
    send_beat(OP_SELECT, 0, 1024);
    send_beat(OP_SELECT, 0, 8192);
    run_job(1024, 1019, 5, 6, 2, 1'b1, 0);
    write_node_count(1);
    run_job(1, 0, 1, 3, 2, 1'b0, 0);
    send_noise(1);
  endtask

  // Fills the selection list and pushes one more select.
  task automatic test_list_full();
    set_phase(1);
    send_beat(OP_CLEAR, 0, 0);
    for (int i = 0; i <= NodeLimit; i++) send_beat(OP_SELECT, 0, 0);
    send_beat(OP_CLEAR, 0, 0);
  endtask

  // Random jobs over several node counts, each job in the next idling phase.
  task automatic test_random_jobs();
    int job;
    int unsigned n;
    int unsigned m;
    job = 0;
    while (job < 4 || sent < 1100) begin
      if (job % 3 == 0) begin
        case ($urandom_range(3))
          0: n = 1;
          1: n = NodeLimit;
          default: n = $urandom_range(2, 64);
        endcase
        write_node_count(n);
      end
      set_phase(job);
      m = $urandom_range(1, (n < 16) ? n : 16);
      run_job(n, $urandom_range(0, n - m), m, $urandom_range(1, m + 3),
              $urandom_range(0, 3), ($urandom_range(7) == 0), 10);
      job++;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.payload = '0;
    fails = 0;
    sent = 0;
    gap_pct = 0;
    stall_pct = 0;
    node_cfg = NodeLimit;
    reset_job();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_list_full();
    test_random_jobs();
    drain();
    repeat (SettleCycles) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
